### src/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, register codes and sideband types of the ray/sphere unit.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int ENTRY_W   = 16;
    localparam int ROW_W     = 64;
    localparam int CENTER_W  = 48;
    localparam int RADIUS_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam int XFORM_W = 25;
    localparam int OC_W    = XFORM_W + 1;
    localparam int A_W     = 50;
    localparam int H_W     = 52;
    localparam int CC_W    = 54;
    localparam int HMAG_W  = 52;
    localparam int CMAG_W  = 53;
    localparam int SPLIT   = 26;
    localparam int DISC_W  = 104;
    localparam int ROOT_W  = DISC_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int NUM_W   = 54;
    localparam int MAG_W   = 53;
    localparam int T_W     = 32;
    localparam int T_FRAC  = 16;
    localparam int Q_W     = T_W + 1;

    localparam int XF_LAT = 3;
    localparam int QD_LAT = 6;
    localparam int SQ_LAT = ROOT_W;
    localparam int DV_LAT = Q_W + 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X,
        CFG_ROW_Y,
        CFG_ROW_Z,
        CFG_CENTER,
        CFG_RADIUS
    } cfg_idx_t;

    typedef struct packed {
        logic                  hit;
        logic [A_W-1:0]        a;
        logic signed [H_W-1:0] h;
    } quad_side_t;

endpackage

### src/ray_sphere_intersect.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Pipelined ray/sphere hit test with an affine inverse object transform.
// ----------------------------------------------------------------------------
// A ray is taken on a rising edge where start is high and busy is low; busy
// stays low, so a new ray may enter in every cycle. Ray fields are signed
// fixed point with FRAC_BITS fraction bits.
// Each ray produces one result, shown for one cycle with done high: hit,
// both roots in Q16.16, and the first root above zero. The pipeline has 3
// transform stages, 6 coefficient and discriminant stages, 52 square root
// stages (one root bit each), 37 divider stages (3 setup stages, 33 stages
// of one quotient bit each with both roots side by side, 1 saturation
// stage) and the output register.
// Throughput is one ray per cycle.
// The receiver cannot hold results off; done is a plain strobe.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// always has cfg_ready high; a transfer to an unknown index is dropped.
// Write registers only while no ray is in flight; the block does not enforce it.
// Reset clears the pipeline valid bits and loads the identity transform,
// a zero center and a radius of one.
// ----------------------------------------------------------------------------
module ray_sphere_intersect #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [COORD_WIDTH-1:0]    origin_x,
    input  logic signed [COORD_WIDTH-1:0]    origin_y,
    input  logic signed [COORD_WIDTH-1:0]    origin_z,
    input  logic signed [COORD_WIDTH-1:0]    dir_x,
    input  logic signed [COORD_WIDTH-1:0]    dir_y,
    input  logic signed [COORD_WIDTH-1:0]    dir_z,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rsi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsi_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             done,
    output logic                             hit,
    output logic signed [rsi_pkg::T_W-1:0]   t_near,
    output logic signed [rsi_pkg::T_W-1:0]   t_far,
    output logic                             front_valid,
    output logic signed [rsi_pkg::T_W-1:0]   front_t
);
    import rsi_pkg::*;

    localparam int LAT = XF_LAT + QD_LAT + SQ_LAT + DV_LAT + 1;

    logic [ROW_W-1:0]    row_reg [3];
    logic [CENTER_W-1:0] center_reg;
    logic [RADIUS_W-1:0] radius_reg;

    logic signed [COORD_WIDTH-1:0] org [3];
    logic signed [COORD_WIDTH-1:0] dir [3];
    logic                   xf_valid, qd_valid, sq_valid, dv_valid, dv_hit;
    logic signed [XFORM_W-1:0] d_v [3];
    logic signed [OC_W-1:0]    oc_v [3];
    logic [DISC_W-1:0]      disc;
    quad_side_t             qd_side, sq_side;
    logic [ROOT_W-1:0]      root;
    logic signed [T_W-1:0]  t0, t1;

    logic                   done_reg, hit_reg, fv_reg;
    logic signed [T_W-1:0]  tn_reg, tf_reg, ft_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign org = '{origin_x, origin_y, origin_z};
    assign dir = '{dir_x, dir_y, dir_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_W'(64'd256);
            row_reg[1] <= ROW_W'(64'd16777216);
            row_reg[2] <= ROW_W'(64'd1099511627776);
            center_reg <= '0;
            radius_reg <= RADIUS_W'(16'd256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROW_X:  row_reg[0] <= cfg_data;
                CFG_ROW_Y:  row_reg[1] <= cfg_data;
                CFG_ROW_Z:  row_reg[2] <= cfg_data;
                CFG_CENTER: center_reg <= cfg_data[CENTER_W-1:0];
                CFG_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                default:    ;
            endcase
        end
    end

    rsi_xform #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .org       (org),
        .dir       (dir),
        .row       (row_reg),
        .center    (center_reg),
        .out_valid (xf_valid),
        .d_out     (d_v),
        .oc_out    (oc_v)
    );

    rsi_quad u_quad (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xf_valid),
        .d_in      (d_v),
        .oc_in     (oc_v),
        .radius    (radius_reg),
        .out_valid (qd_valid),
        .disc      (disc),
        .side      (qd_side)
    );

    rsi_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qd_valid),
        .disc      (disc),
        .side_in   (qd_side),
        .out_valid (sq_valid),
        .root      (root),
        .side_out  (sq_side)
    );

    rsi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .root      (root),
        .side      (sq_side),
        .out_valid (dv_valid),
        .out_hit   (dv_hit),
        .t0        (t0),
        .t1        (t1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid;
    end

    // misses report zero everywhere
    always_ff @(posedge clk)
    begin
        hit_reg <= dv_hit;
        tn_reg  <= dv_hit ? t0 : '0;
        tf_reg  <= dv_hit ? t1 : '0;
        fv_reg  <= dv_hit && (t0 > 0 || t1 > 0);
        if (dv_hit && t0 > 0)
            ft_reg <= t0;
        else if (dv_hit && t1 > 0)
            ft_reg <= t1;
        else
            ft_reg <= '0;
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign t_near      = tn_reg;
    assign t_far       = tf_reg;
    assign front_valid = fv_reg;
    assign front_t     = ft_reg;

    a_done_has_ray: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a ray taken");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> t_near == '0 && t_far == '0 && !front_valid && front_t == '0)
        else $error("miss with nonzero fields");

    a_root_order: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> t_near <= t_far)
        else $error("roots out of order");

    a_front_pick: assert property (@(posedge clk) disable iff (!rst_n)
        done && front_valid |-> front_t > 0 && (front_t == t_near || front_t == t_far))
        else $error("front root not a positive root");

endmodule

### src/rsi_xform.sv
// ----------------------------------------------------------------------------
// rsi_xform
// Maps the ray through the inverse transform and offsets it by the center.
// ----------------------------------------------------------------------------
module rsi_xform #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [COORD_WIDTH-1:0]     org [3],
    input  logic signed [COORD_WIDTH-1:0]     dir [3],
    input  logic [rsi_pkg::ROW_W-1:0]         row [3],
    input  logic [rsi_pkg::CENTER_W-1:0]      center,
    output logic                              out_valid,
    output logic signed [rsi_pkg::XFORM_W-1:0] d_out [3],
    output logic signed [rsi_pkg::OC_W-1:0]   oc_out [3]
);
    import rsi_pkg::*;

    localparam int PW = ENTRY_W + COORD_WIDTH;
    localparam int TW = ENTRY_W + FRAC_BITS;
    localparam int SW = ((PW > TW) ? PW : TW) + 2;

    logic                   v1_reg, v2_reg, v3_reg;
    logic signed [PW-1:0]   po_reg [3][3];
    logic signed [PW-1:0]   pd_reg [3][3];
    logic signed [ENTRY_W-1:0] tr_reg [3];
    logic signed [XFORM_W-1:0] o_reg [3];
    logic signed [XFORM_W-1:0] d2_reg [3];
    logic signed [XFORM_W-1:0] d_next [3];
    logic signed [XFORM_W-1:0] o_next [3];
    logic signed [XFORM_W-1:0] d3_reg [3];
    logic signed [OC_W-1:0]    oc_reg [3];

    function automatic logic signed [XFORM_W-1:0] round_clamp(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] sh;
        logic signed [63:0]   wide;
        sh   = (s + SW'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        wide = 64'(sh);
        if (wide > 64'sd16777215)
            return XFORM_W'(24'hFFFFFF);
        else if (wide < -64'sd16777216)
            return {1'b1, {(XFORM_W-1){1'b0}}};
        else
            return XFORM_W'(wide);
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            o_next[i] = round_clamp(SW'(po_reg[i][0]) + SW'(po_reg[i][1]) + SW'(po_reg[i][2])
                                    + (SW'(tr_reg[i]) <<< FRAC_BITS));
            d_next[i] = round_clamp(SW'(pd_reg[i][0]) + SW'(pd_reg[i][1])
                                    + SW'(pd_reg[i][2]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            tr_reg[i] <= $signed(row[i][3*ENTRY_W +: ENTRY_W]);
            for (int k = 0; k < 3; k++)
            begin
                po_reg[i][k] <= $signed(row[i][k*ENTRY_W +: ENTRY_W]) * org[k];
                pd_reg[i][k] <= $signed(row[i][k*ENTRY_W +: ENTRY_W]) * dir[k];
            end
            o_reg[i]  <= o_next[i];
            d2_reg[i] <= d_next[i];
            d3_reg[i] <= d2_reg[i];
            oc_reg[i] <= OC_W'(o_reg[i]) - OC_W'($signed(center[i*ENTRY_W +: ENTRY_W]));
        end
    end

    assign out_valid = v3_reg;
    assign d_out     = d3_reg;
    assign oc_out    = oc_reg;

endmodule

### src/rsi_quad.sv
// ----------------------------------------------------------------------------
// rsi_quad
// Quadratic coefficients and the discriminant in the half-b form.
// ----------------------------------------------------------------------------
module rsi_quad (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [rsi_pkg::XFORM_W-1:0] d_in [3],
    input  logic signed [rsi_pkg::OC_W-1:0]    oc_in [3],
    input  logic [rsi_pkg::RADIUS_W-1:0]       radius,
    output logic                               out_valid,
    output logic [rsi_pkg::DISC_W-1:0]         disc,
    output rsi_pkg::quad_side_t                side
);
    import rsi_pkg::*;

    logic [QD_LAT-1:0] v_reg;

    // stage 1: products
    logic signed [2*XFORM_W-1:0]    dd_reg [3];
    logic signed [XFORM_W+OC_W-1:0] dh_reg [3];
    logic signed [2*OC_W-1:0]       cp_reg [3];
    logic [2*RADIUS_W-1:0]          rr_reg;
    // stage 2: sums
    logic [A_W-1:0]        a2_reg;
    logic signed [H_W-1:0] h2_reg;
    logic signed [CC_W-1:0] cc_reg;
    logic signed [A_W+1:0] a_sum;
    // stage 3: magnitudes
    logic [A_W-1:0]        a3_reg;
    logic signed [H_W-1:0] h3_reg;
    logic [HMAG_W-1:0]     ah_reg;
    logic [CMAG_W-1:0]     acc_reg;
    logic                  anz3_reg, le3_reg;
    // stage 4: partial products
    logic [A_W-1:0]        a4_reg;
    logic signed [H_W-1:0] h4_reg;
    logic                  anz4_reg, le4_reg;
    logic [2*SPLIT-1:0]    hll_reg, hlh_reg, hhh_reg, all_reg;
    logic [2*SPLIT:0]      alh_reg;
    logic [A_W-SPLIT+SPLIT-1:0] ahl_reg;
    logic [A_W-SPLIT+CMAG_W-SPLIT-1:0] ahh_reg;
    // stage 5: full products
    logic [A_W-1:0]        a5_reg;
    logic signed [H_W-1:0] h5_reg;
    logic                  anz5_reg, le5_reg;
    logic [DISC_W-1:0]     hh_reg, ac_reg;
    // stage 6: discriminant
    logic [DISC_W-1:0]     disc_reg, disc_next;
    logic                  hit_next;
    quad_side_t            side_reg;

    assign a_sum = (A_W+2)'(dd_reg[0]) + (A_W+2)'(dd_reg[1]) + (A_W+2)'(dd_reg[2]);

    always_comb
    begin
        hit_next  = anz5_reg;
        disc_next = hh_reg + ac_reg;
        if (!le5_reg)
        begin
            disc_next = hh_reg - ac_reg;
            if (hh_reg < ac_reg)
                hit_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[QD_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dd_reg[i] <= d_in[i] * d_in[i];
            dh_reg[i] <= d_in[i] * oc_in[i];
            cp_reg[i] <= oc_in[i] * oc_in[i];
        end
        rr_reg <= radius * radius;

        a2_reg <= A_W'(a_sum);
        h2_reg <= H_W'(dh_reg[0]) + H_W'(dh_reg[1]) + H_W'(dh_reg[2]);
        cc_reg <= CC_W'(cp_reg[0]) + CC_W'(cp_reg[1]) + CC_W'(cp_reg[2])
                  - CC_W'(rr_reg);

        a3_reg   <= a2_reg;
        h3_reg   <= h2_reg;
        ah_reg   <= HMAG_W'(h2_reg < 0 ? -h2_reg : h2_reg);
        acc_reg  <= CMAG_W'(cc_reg < 0 ? -cc_reg : cc_reg);
        anz3_reg <= (a2_reg != '0);
        le3_reg  <= (cc_reg <= 0);

        a4_reg   <= a3_reg;
        h4_reg   <= h3_reg;
        anz4_reg <= anz3_reg;
        le4_reg  <= le3_reg;
        hll_reg  <= ah_reg[SPLIT-1:0] * ah_reg[SPLIT-1:0];
        hlh_reg  <= ah_reg[SPLIT-1:0] * ah_reg[HMAG_W-1:SPLIT];
        hhh_reg  <= ah_reg[HMAG_W-1:SPLIT] * ah_reg[HMAG_W-1:SPLIT];
        all_reg  <= a3_reg[SPLIT-1:0] * acc_reg[SPLIT-1:0];
        alh_reg  <= a3_reg[SPLIT-1:0] * acc_reg[CMAG_W-1:SPLIT];
        ahl_reg  <= a3_reg[A_W-1:SPLIT] * acc_reg[SPLIT-1:0];
        ahh_reg  <= a3_reg[A_W-1:SPLIT] * acc_reg[CMAG_W-1:SPLIT];

        a5_reg   <= a4_reg;
        h5_reg   <= h4_reg;
        anz5_reg <= anz4_reg;
        le5_reg  <= le4_reg;
        // cross term of the square appears twice
        hh_reg   <= DISC_W'(hll_reg) + (DISC_W'(hlh_reg) << (SPLIT + 1))
                    + (DISC_W'(hhh_reg) << (2 * SPLIT));
        ac_reg   <= DISC_W'(all_reg) + (DISC_W'(alh_reg) << SPLIT)
                    + (DISC_W'(ahl_reg) << SPLIT) + (DISC_W'(ahh_reg) << (2 * SPLIT));

        disc_reg     <= disc_next;
        side_reg.hit <= hit_next;
        side_reg.a   <= a5_reg;
        side_reg.h   <= h5_reg;
    end

    assign out_valid = v_reg[QD_LAT-1];
    assign disc      = disc_reg;
    assign side      = side_reg;

endmodule

### src/rsi_sqrt.sv
// ----------------------------------------------------------------------------
// rsi_sqrt
// Floor integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module rsi_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [rsi_pkg::DISC_W-1:0] disc,
    input  rsi_pkg::quad_side_t        side_in,
    output logic                       out_valid,
    output logic [rsi_pkg::ROOT_W-1:0] root,
    output rsi_pkg::quad_side_t        side_out
);
    import rsi_pkg::*;

    logic [ROOT_W-1:0] v_reg;
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [DISC_W-1:0] dsh_reg  [ROOT_W];
    quad_side_t        side_reg [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_step
        logic              v_in;
        logic [REM_W-1:0]  rem_in, rem_next, r2, trial;
        logic [ROOT_W-1:0] root_in, root_next;
        logic [DISC_W-1:0] dsh_in;
        quad_side_t        side_s;

        if (j == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign dsh_in  = disc;
            assign side_s  = side_in;
        end
        else
        begin : g_next
            assign v_in    = v_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign dsh_in  = dsh_reg[j-1];
            assign side_s  = side_reg[j-1];
        end

        // bring down the next two bits and try root*4+1
        assign r2    = {rem_in[REM_W-3:0], dsh_in[DISC_W-1 -: 2]};
        assign trial = {root_in, 2'b01};

        always_comb
        begin
            if (r2 >= trial)
            begin
                rem_next  = r2 - trial;
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = r2;
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= rem_next;
            root_reg[j] <= root_next;
            dsh_reg[j]  <= dsh_in << 2;
            side_reg[j] <= side_s;
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

### src/rsi_div.sv
// ----------------------------------------------------------------------------
// rsi_div
// Both roots as (num * 2^16) / a, restoring division, two lanes in lockstep.
// ----------------------------------------------------------------------------
module rsi_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [rsi_pkg::ROOT_W-1:0]    root,
    input  rsi_pkg::quad_side_t           side,
    output logic                          out_valid,
    output logic                          out_hit,
    output logic signed [rsi_pkg::T_W-1:0] t0,
    output logic signed [rsi_pkg::T_W-1:0] t1
);
    import rsi_pkg::*;

    localparam int SHR = Q_W - T_FRAC;

    logic [3:0] vp_reg;
    logic [Q_W-1:0] vs_reg;

    logic signed [NUM_W-1:0] h_ext, s_ext;
    logic signed [NUM_W-1:0] num_reg [2];
    logic [A_W-1:0] a1_reg, a2_reg, a3_reg;
    logic           hit1_reg, hit2_reg, hit3_reg;
    logic [MAG_W-1:0] mag_reg [2];
    logic           neg2_reg [2];
    logic           neg3_reg [2];
    logic           ovf3_reg [2];
    logic [A_W-1:0] rem3_reg [2];
    logic [Q_W-1:0] low3_reg [2];

    logic [A_W-1:0] a_s_reg   [Q_W];
    logic           hit_s_reg [Q_W];
    logic           neg_s_reg [Q_W][2];
    logic           ovf_s_reg [Q_W][2];
    logic [A_W-1:0] rem_s_reg [Q_W][2];
    logic [Q_W-1:0] low_s_reg [Q_W][2];
    logic [Q_W-1:0] q_s_reg   [Q_W][2];

    logic signed [T_W-1:0] t_reg [2];
    logic                  hit_o_reg;
    logic signed [T_W-1:0] t_next [2];

    assign h_ext = NUM_W'(side.h);
    assign s_ext = $signed(NUM_W'(root));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp_reg <= '0;
        else
        begin
            vp_reg[0] <= in_valid;
            vp_reg[1] <= vp_reg[0];
            vp_reg[2] <= vp_reg[1];
            vp_reg[3] <= vs_reg[Q_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg[0] <= -h_ext - s_ext;
        num_reg[1] <= -h_ext + s_ext;
        a1_reg     <= side.a;
        hit1_reg   <= side.hit;

        a2_reg   <= a1_reg;
        hit2_reg <= hit1_reg;
        a3_reg   <= a2_reg;
        hit3_reg <= hit2_reg;
        for (int l = 0; l < 2; l++)
        begin
            neg2_reg[l] <= num_reg[l] < 0;
            mag_reg[l]  <= MAG_W'(num_reg[l] < 0 ? -num_reg[l] : num_reg[l]);
            // quotient of 2^33 or more always saturates
            neg3_reg[l] <= neg2_reg[l];
            ovf3_reg[l] <= (mag_reg[l] >> SHR) >= MAG_W'(a2_reg);
            rem3_reg[l] <= A_W'(mag_reg[l] >> SHR);
            low3_reg[l] <= {mag_reg[l][SHR-1:0], {T_FRAC{1'b0}}};
        end
    end

    for (genvar j = 0; j < Q_W; j++)
    begin : g_step
        logic           v_in, hit_in;
        logic [A_W-1:0] a_in;
        logic           neg_in [2];
        logic           ovf_in [2];
        logic [A_W-1:0] rem_in [2];
        logic [Q_W-1:0] low_in [2];
        logic [Q_W-1:0] q_in   [2];
        logic [A_W:0]   r2     [2];
        logic [A_W-1:0] rem_next [2];
        logic [Q_W-1:0] q_next   [2];

        if (j == 0)
        begin : g_first
            assign v_in   = vp_reg[2];
            assign hit_in = hit3_reg;
            assign a_in   = a3_reg;
            assign neg_in = neg3_reg;
            assign ovf_in = ovf3_reg;
            assign rem_in = rem3_reg;
            assign low_in = low3_reg;
            assign q_in   = '{default: '0};
        end
        else
        begin : g_next
            assign v_in   = vs_reg[j-1];
            assign hit_in = hit_s_reg[j-1];
            assign a_in   = a_s_reg[j-1];
            assign neg_in = neg_s_reg[j-1];
            assign ovf_in = ovf_s_reg[j-1];
            assign rem_in = rem_s_reg[j-1];
            assign low_in = low_s_reg[j-1];
            assign q_in   = q_s_reg[j-1];
        end

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                r2[l] = {rem_in[l], low_in[l][Q_W-1]};
                if (r2[l] >= {1'b0, a_in})
                begin
                    rem_next[l] = A_W'(r2[l] - {1'b0, a_in});
                    q_next[l]   = {q_in[l][Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = A_W'(r2[l]);
                    q_next[l]   = {q_in[l][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vs_reg[j] <= 1'b0;
            else
                vs_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            a_s_reg[j]   <= a_in;
            hit_s_reg[j] <= hit_in;
            for (int l = 0; l < 2; l++)
            begin
                neg_s_reg[j][l] <= neg_in[l];
                ovf_s_reg[j][l] <= ovf_in[l];
                rem_s_reg[j][l] <= rem_next[l];
                low_s_reg[j][l] <= low_in[l] << 1;
                q_s_reg[j][l]   <= q_next[l];
            end
        end
    end

    // saturate to the signed 32-bit range
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (neg_s_reg[Q_W-1][l])
            begin
                if (ovf_s_reg[Q_W-1][l] || q_s_reg[Q_W-1][l] > Q_W'(33'h080000000))
                    t_next[l] = {1'b1, {(T_W-1){1'b0}}};
                else
                    t_next[l] = -$signed(q_s_reg[Q_W-1][l][T_W-1:0]);
            end
            else
            begin
                if (ovf_s_reg[Q_W-1][l] || q_s_reg[Q_W-1][l] > Q_W'(33'h07FFFFFFF))
                    t_next[l] = {1'b0, {(T_W-1){1'b1}}};
                else
                    t_next[l] = $signed(q_s_reg[Q_W-1][l][T_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        hit_o_reg <= hit_s_reg[Q_W-1];
    end

    assign out_valid = vp_reg[3];
    assign out_hit   = hit_o_reg;
    assign t0        = t_reg[0];
    assign t1        = t_reg[1];

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ray_sphere_intersect: directed rays at the reset
// transform, then random rays there and under several transform/sphere settings,
// scored against listed results or a bit-exact fixed-point intersection predictor.
// ----------------------------------------------------------------------------
module testbench;
    import rsi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = '1;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 300000;
    localparam logic signed [T_W-1:0] ONE_Q16 = 32'sd65536;

    typedef struct packed {
        logic signed [15:0] ox, oy, oz, dx, dy, dz;
    } ray_t;

    typedef struct packed {
        logic                  hit;
        logic signed [T_W-1:0] t_near;
        logic signed [T_W-1:0] t_far;
        logic                  front_valid;
        logic signed [T_W-1:0] front_t;
    } isect_t;

    typedef struct packed {
        ray_t   ray;
        logic   known;
        isect_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic done, hit, front_valid;
    logic signed [T_W-1:0] t_near, t_far, front_t;

    ray_sphere_intersect u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .hit(hit), .t_near(t_near), .t_far(t_far),
        .front_valid(front_valid), .front_t(front_t)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // local copy of the registers
    logic [ROW_W-1:0]    xf_row [3];
    logic [CENTER_W-1:0] center_q;
    logic [RADIUS_W-1:0] radius_q;

    isect_t pending_hits [$];
    row_t   directed_rows [$];
    int mismatches = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int front_seen = 0;
    int cycles = 0;

    function automatic longint entry_of(logic [63:0] word, int k);
        logic signed [15:0] e;
        e = word[16*k +: 16];
        return longint'(e);
    endfunction

    function automatic longint clamp25(longint v);
        if (v > 64'sd16777215) return 64'sd16777215;
        if (v < -64'sd16777216) return -64'sd16777216;
        return v;
    endfunction

    function automatic logic signed [T_W-1:0] root_to_q16(longint num, longint a);
        logic [127:0] mag, q;
        mag = (num < 0) ? 128'(-num) : 128'(num);
        q = (mag << 16) / 128'(a);
        if (num < 0)
        begin
            if (q > 128'h8000_0000) return 32'sh8000_0000;
            return -$signed(q[31:0]);
        end
        if (q > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
        return $signed(q[31:0]);
    endfunction

    function automatic isect_t predict_isect(ray_t r);
        longint in_o [3], in_d [3], o, d [3], oc [3];
        longint so, sd, a, h, cc, rr, sq;
        logic signed [127:0] hw, aw, cw, disc;
        logic [127:0] s, c;
        isect_t res;
        in_o = '{longint'(r.ox), longint'(r.oy), longint'(r.oz)};
        in_d = '{longint'(r.dx), longint'(r.dy), longint'(r.dz)};
        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            so = entry_of(xf_row[i], 3) * 256;
            sd = 0;
            for (int k = 0; k < 3; k++)
            begin
                so += entry_of(xf_row[i], k) * in_o[k];
                sd += entry_of(xf_row[i], k) * in_d[k];
            end
            o = clamp25((so + 128) >>> 8);
            d[i] = clamp25((sd + 128) >>> 8);
            oc[i] = o - entry_of({16'h0, center_q}, i);
        end
        a = 0; h = 0; cc = 0;
        for (int i = 0; i < 3; i++)
        begin
            a += d[i] * d[i];
            h += d[i] * oc[i];
            cc += oc[i] * oc[i];
        end
        rr = longint'(radius_q);
        cc -= rr * rr;
        if (a == 0) return res;
        hw = 128'(h); aw = 128'(a); cw = 128'(cc);
        disc = hw * hw - aw * cw;
        if (disc < 0) return res;
        s = '0;
        for (int i = 59; i >= 0; i--)
        begin
            c = s | (128'd1 << i);
            if (c * c <= $unsigned(disc)) s = c;
        end
        sq = longint'(s);
        res.hit = 1'b1;
        res.t_near = root_to_q16(-h - sq, a);
        res.t_far = root_to_q16(-h + sq, a);
        if (res.t_near > 0)
        begin
            res.front_valid = 1'b1;
            res.front_t = res.t_near;
        end
        else if (res.t_far > 0)
        begin
            res.front_valid = 1'b1;
            res.front_t = res.t_far;
        end
        return res;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ROW_X:  xf_row[0] = value;
            CFG_ROW_Y:  xf_row[1] = value;
            CFG_ROW_Z:  xf_row[2] = value;
            CFG_CENTER: center_q = value[CENTER_W-1:0];
            CFG_RADIUS: radius_q = value[RADIUS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_scene(logic [63:0] rx, logic [63:0] ry, logic [63:0] rz,
                              logic [63:0] ctr, logic [63:0] rad);
        write_reg(CFG_ROW_X, rx);
        write_reg(CFG_ROW_Y, ry);
        write_reg(CFG_ROW_Z, rz);
        write_reg(CFG_CENTER, ctr);
        write_reg(CFG_RADIUS, rad);
        // unknown index must leave everything alone
        write_reg(CFG_IDX_UNUSED, {$urandom, $urandom});
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_hits.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_ray(ray_t r, logic known, isect_t want, bit idle_ok);
        if (idle_ok && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        start <= 1'b1;
        origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
        dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
        do @(posedge clk); while (busy);
        pending_hits.push_back(known ? want : predict_isect(r));
    endtask

    function automatic logic signed [15:0] rand_in(int span);
        return 16'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // aimed rays hit far more often than raw noise
    function automatic ray_t aimed_ray(int span);
        ray_t r;
        if ($urandom_range(0, 4) == 0)
            r = {$urandom, $urandom, $urandom};
        else
        begin
            r.ox = rand_in(span); r.oy = rand_in(span); r.oz = rand_in(span);
            r.dx = 16'(-(r.ox >>> 2)) + rand_in(64);
            r.dy = 16'(-(r.oy >>> 2)) + rand_in(64);
            r.dz = 16'(-(r.oz >>> 2)) + rand_in(64);
        end
        return r;
    endfunction

    task automatic random_rays(int count, int span, bit idle_ok);
        for (int n = 0; n < count; n++)
        begin
            send_ray(aimed_ray(span), 1'b0, '0, idle_ok);
            if (n == count / 2 && idle_ok) drain();
        end
    endtask

    task automatic add_row(ray_t r, logic known, isect_t want);
        row_t row;
        row.ray = r; row.known = known; row.want = want;
        directed_rows.push_back(row);
    endtask

    // scoreboard
    always @(posedge clk)
    begin
        isect_t got, want;
        if (done)
        begin
            got = {hit, t_near, t_far, front_valid, front_t};
            results_seen++;
            hits_seen += hit;
            front_seen += front_valid;
            if (pending_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_hits.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected hit=%0d near=%0d far=%0d fv=%0d ft=%0d,",
                                  " got hit=%0d near=%0d far=%0d fv=%0d ft=%0d"},
                                 want.hit, want.t_near, want.t_far, want.front_valid,
                                 want.front_t, got.hit, got.t_near, got.t_far,
                                 got.front_valid, got.front_t);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** ray_sphere_intersect: FAILED **");
            $finish;
        end
    end

    initial
    begin
        isect_t none;
        none = '0;
        xf_row[0] = 64'd256;
        xf_row[1] = 64'd16777216;
        xf_row[2] = 64'd1099511627776;
        center_q = '0;
        radius_q = 16'd256;

        // unit sphere at origin, identity transform
        add_row('{-512, 0, 0, 256, 0, 0}, 1'b1, '{1'b1, ONE_Q16, 3 * ONE_Q16, 1'b1, ONE_Q16});
        add_row('{0, 0, 0, 256, 0, 0}, 1'b1, '{1'b1, -ONE_Q16, ONE_Q16, 1'b1, ONE_Q16});
        add_row('{512, 0, 0, 256, 0, 0}, 1'b1, '{1'b1, -3 * ONE_Q16, -ONE_Q16, 1'b0, 0});
        add_row('{0, 512, -512, 0, 0, 256}, 1'b1, none);  // misses
        add_row('{-512, 0, 0, 0, 0, 0}, 1'b1, none);      // zero direction
        add_row('{0, 0, 0, 0, 0, 0}, 1'b1, none);
        add_row('{-512, 256, 0, 256, 0, 0}, 1'b0, none);  // tangent
        add_row('{-32768, 0, 0, 1, 0, 0}, 1'b0, none);    // root saturates
        add_row('{32767, 0, 0, -1, 0, 0}, 1'b0, none);
        add_row('{-32768, -32768, -32768, 32767, 32767, 32767}, 1'b0, none);
        add_row('{32767, 32767, 32767, -32768, -32768, -32768}, 1'b0, none);
        add_row('{-32768, 32767, -32768, 32767, -32768, 32767}, 1'b0, none);
        add_row('{0, 0, -1024, 0, 0, 1}, 1'b0, none);
        add_row('{0, 0, 0, -32768, 0, 0}, 1'b0, none);
        add_row('{100, -200, 50, 3, -7, 11}, 1'b0, none);
        add_row('{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, none);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_ray(directed_rows[i].ray, directed_rows[i].known, directed_rows[i].want, 1'b1);
        random_rays(120, 1024, 1'b1);
        drain();

        // scaled transform with translation, offset sphere
        load_scene({16'($signed($urandom_range(0, 512)) - 256), 48'h0000_0000_0200},
                   {16'h0040, 48'h0000_0200_0000}, {16'hFF80, 48'h0200_0000_0000},
                   {16'h0100, 16'hFF00, 16'h0080}, 64'd512);
        random_rays(160, 2048, 1'b1);
        drain();

        // fully random registers
        load_scene({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
        random_rays(140, 32767, 1'b1);
        drain();

        // extremes: full-scale rows, far center, largest radius
        load_scene({4{16'h7FFF}}, {4{16'h8000}}, {4{16'hFFFF}},
                   {16'h0, 16'h8000, 16'h7FFF, 16'h8000}, 64'hFFFF_FFFF_FFFF_FFFF);
        random_rays(100, 32767, 1'b1);
        drain();

        // zero linear part: every ray has a zero direction
        load_scene({16'h0100, 48'h0}, {16'hFF00, 48'h0}, {16'h7FFF, 48'h0},
                   64'h0, 64'h0);
        random_rays(40, 32767, 1'b1);
        drain();

        // zero radius, mild transform
        load_scene(64'h0000_0000_0000_0180, 64'h0000_0000_0100_0000,
                   64'h0000_0100_0000_0000, {16'h0, 16'h0040, 16'h0, 16'hFFC0}, 64'h0);
        random_rays(60, 1024, 1'b1);
        drain();

        // back to a friendly scene, back-to-back rays
        load_scene(64'h0000_0000_0000_0100, 64'h0000_0000_0100_0000,
                   64'h0000_0100_0000_0000, {16'h0, 16'h0100, 16'h0, 16'hFF00}, 64'd640);
        random_rays(230, 1536, 1'b0);
        drain();

        $display("covered %0d results (%0d hits, %0d in front) over seven register settings",
                 results_seen, hits_seen, front_seen);
        $display("directed extremes, saturated roots, misses, zero directions and zero radius");
        if (mismatches == 0 && pending_hits.size() == 0)
            $display("** ray_sphere_intersect: PASSED **");
        else
            $display("** ray_sphere_intersect: FAILED **");
        $finish;
    end

endmodule

### sim.f
src/rsi_pkg.sv
src/rsi_xform.sv
src/rsi_quad.sv
src/rsi_sqrt.sv
src/rsi_div.sv
src/ray_sphere_intersect.sv
sim/testbench.sv
